[sv/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // End status codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_PADDING  = 3'd2;
  localparam logic [2:0] ERR_LEN_ONE  = 3'd3;
  localparam logic [2:0] ERR_TRAILING = 3'd4;

  // Special characters
  localparam logic [7:0] CHAR_PAD   = 8'h3d; // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2b; // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2f; // '/'
  localparam logic [7:0] CHAR_MINUS = 8'h2d; // '-'
  localparam logic [7:0] CHAR_UNDER = 8'h5f; // '_'

  localparam logic [5:0] SYM_62 = 6'd62;
  localparam logic [5:0] SYM_63 = 6'd63;

  // One result beat as it leaves the decode logic
  typedef struct packed {
    logic       emit;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    logic [2:0] error_code;
  } b64d_result_t;

  // Symbol lookup: bit 6 set means the character is not in the alphabet
  function automatic logic [6:0] symbol_lookup(input logic [7:0] c, input logic url);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      symbol_lookup = {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h61 + 8'd26;
      symbol_lookup = {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      symbol_lookup = {1'b0, d[5:0]};
    end else if (url && c == CHAR_MINUS) begin
      symbol_lookup = {1'b0, SYM_62};
    end else if (url && c == CHAR_UNDER) begin
      symbol_lookup = {1'b0, SYM_63};
    end else if (!url && c == CHAR_PLUS) begin
      symbol_lookup = {1'b0, SYM_62};
    end else if (!url && c == CHAR_SLASH) begin
      symbol_lookup = {1'b0, SYM_63};
    end else begin
      symbol_lookup = 7'h40;
    end
  endfunction

endpackage

[sv/base64_strict_decoder.sv]
// ----------------------------------------------------------------------------
// base64_strict_decoder
// Strict Base64 decoder, one character per beat, standard or URL alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one character per beat, last_char
//   marks the final character of a message. Output channel
//   (out_valid/out_ready): a beat whenever a byte completes, and always on
//   the final character, carrying message_end and error_code.
//   cfg_write/cfg_data set url_alphabet; write it only between messages.
//   A result is registered when its character is accepted. Throughput:
//   one character per cycle while in_ready is high, set by the decode
//   step that runs between the message state and the output register.
//   Reset clears the message state, selects the standard alphabet and
//   empties the output. When the receiver stalls, a second result is held
//   in a skid register; in_ready drops only while that register is full.
//   A message with a nonzero error_code is to be discarded by the receiver.
// ----------------------------------------------------------------------------
module base64_strict_decoder
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       message_end,
  output logic [2:0] error_code
);

  logic         url_alphabet;
  logic         beat;
  logic         push;
  logic         out_free;
  logic         skid_valid;
  b64d_result_t step_res;
  b64d_result_t out_reg;
  b64d_result_t skid_reg;

  assign in_ready = !skid_valid;
  assign beat     = in_valid && in_ready;
  assign push     = beat && step_res.emit;
  assign out_free = !out_valid || out_ready;

  b64d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .character (character),
    .last_char (last_char),
    .url       (url_alphabet),
    .result    (step_res)
  );

  // Config and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_write) url_alphabet <= cfg_data;
      if (out_free) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (push)  out_reg <= step_res;
    end else if (push) begin
      skid_reg <= step_res;
    end
  end

  assign data_byte   = out_reg.data_byte;
  assign byte_valid  = out_reg.byte_valid;
  assign message_end = out_reg.message_end;
  assign error_code  = out_reg.error_code;

`ifndef SYNTH
  a_err_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |-> message_end)
    else $error("error status without message end");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0)
    else $error("data byte nonzero without byte_valid");

  a_beat_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("result beat lost");
`endif

endmodule

[sv/b64d_core.sv]
// ----------------------------------------------------------------------------
// b64d_core
// Per-message decode state and the single-pass step logic for one character.
// ----------------------------------------------------------------------------
module b64d_core
  import b64d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         beat,
  input  logic [7:0]   character,
  input  logic         last_char,
  input  logic         url,
  output b64d_result_t result
);

  logic [5:0] leftover_bits,     leftover_bits_next;
  logic [2:0] leftover_count,    leftover_count_next;
  logic [5:0] last_symbol,       last_symbol_next;
  logic [1:0] symbol_count_mod4, symbol_count_next;
  logic [1:0] pad_count,         pad_count_next;
  logic       bad_char_seen,     bad_next;

  logic [6:0]  lookup;
  logic [11:0] acc;
  logic        is_pad;
  logic        have_byte;
  logic [7:0]  byte_val;
  logic [1:0]  len_pad;
  logic [2:0]  err;

  // Step logic for the current character
  always_comb begin
    lookup              = symbol_lookup(character, url);
    acc                 = {leftover_bits, lookup[5:0]};
    is_pad              = !url && (character == CHAR_PAD);
    leftover_bits_next  = leftover_bits;
    leftover_count_next = leftover_count;
    last_symbol_next    = last_symbol;
    symbol_count_next   = symbol_count_mod4;
    pad_count_next      = pad_count;
    bad_next            = bad_char_seen;
    have_byte           = 1'b0;
    byte_val            = 8'd0;

    if (is_pad) begin
      // saturating run of '='
      if (pad_count != 2'd3) pad_count_next = pad_count + 2'd1;
    end else begin
      // a '=' run followed by a symbol is misplaced padding
      if (pad_count != 2'd0) bad_next = 1'b1;
      symbol_count_next = symbol_count_mod4 + pad_count + 2'd1;
      pad_count_next    = 2'd0;
      if (lookup[6]) begin
        bad_next = 1'b1;
      end else begin
        last_symbol_next = lookup[5:0];
        unique case (leftover_count)
          3'd2: begin
            have_byte           = 1'b1;
            byte_val            = acc[7:0];
            leftover_bits_next  = 6'd0;
            leftover_count_next = 3'd0;
          end
          3'd4: begin
            have_byte           = 1'b1;
            byte_val            = acc[9:2];
            leftover_bits_next  = {4'd0, acc[1:0]};
            leftover_count_next = 3'd2;
          end
          3'd6: begin
            have_byte           = 1'b1;
            byte_val            = acc[11:4];
            leftover_bits_next  = {2'd0, acc[3:0]};
            leftover_count_next = 3'd4;
          end
          default: begin
            leftover_bits_next  = lookup[5:0];
            leftover_count_next = 3'd6;
          end
        endcase
      end
    end

    // no bytes once the message is known bad
    if (bad_next) begin
      have_byte = 1'b0;
      byte_val  = 8'd0;
    end

    // end status, checked in priority order
    len_pad = symbol_count_next + pad_count_next;
    if (pad_count_next == 2'd3)                         err = ERR_PADDING;
    else if (symbol_count_next == 2'd1)                 err = ERR_LEN_ONE;
    else if (pad_count_next != 2'd0 && len_pad != 2'd0) err = ERR_PADDING;
    else if (bad_next)                                  err = ERR_BAD_CHAR;
    else if ((symbol_count_next == 2'd2 && last_symbol_next[3:0] != 4'd0) ||
             (symbol_count_next == 2'd3 && last_symbol_next[1:0] != 2'd0))
      err = ERR_TRAILING;
    else                                                err = ERR_OK;

    result.emit        = have_byte || last_char;
    result.data_byte   = byte_val;
    result.byte_valid  = have_byte;
    result.message_end = last_char;
    result.error_code  = last_char ? err : ERR_OK;
  end

  // Message state; cleared after the final character
  always_ff @(posedge clk) begin
    if (rst || (beat && last_char)) begin
      leftover_bits     <= 6'd0;
      leftover_count    <= 3'd0;
      last_symbol       <= 6'd0;
      symbol_count_mod4 <= 2'd0;
      pad_count         <= 2'd0;
      bad_char_seen     <= 1'b0;
    end else if (beat) begin
      leftover_bits     <= leftover_bits_next;
      leftover_count    <= leftover_count_next;
      last_symbol       <= last_symbol_next;
      symbol_count_mod4 <= symbol_count_next;
      pad_count         <= pad_count_next;
      bad_char_seen     <= bad_next;
    end
  end

endmodule
